FILE: src/pasm_pkg.sv
package pasm_pkg;

   localparam int COEFF_W = 32;
   localparam int POS_W   = 6;
   localparam int MODE_W  = 2;
   // exact sum of up to 32 full-range 32x32 products, plus rounding headroom
   localparam int ACC_W   = 70;

   localparam logic [MODE_W-1:0] OP_SUM = 2'd0;
   localparam logic [MODE_W-1:0] OP_SUB = 2'd1;
   localparam logic [MODE_W-1:0] OP_MUL = 2'd2;
   localparam int MODE_SUB_BIT = 0;
   localparam int MODE_MUL_BIT = 1;

   localparam logic signed [COEFF_W-1:0] COEFF_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COEFF_W-1:0] COEFF_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_CALC,
      ST_MUL_INIT,
      ST_MUL_ISSUE,
      ST_MUL_DRAIN,
      ST_MUL_OUT
   } state_type;

   typedef struct packed {
      logic                      cmd;
      logic signed [COEFF_W-1:0] coeff_in;
      logic                      last_in;
   } req_type;

   typedef struct packed {
      logic signed [COEFF_W-1:0] coeff_out;
      logic [POS_W-1:0]          power;
      logic                      last_out;
      logic                      saturated;
   } rsp_type;

endpackage

FILE: src/polynomial_add_sub_multiply_top.sv
// Loads: an item is accepted every cycle while idle.
// On the second polynomial's last item: sum/difference reads and then computes each result;
// product clears, issues the result's term pairs, drains them and outputs each result once
// the output slot is free, using the single registered 32x32 multiplier fed one term pair per cycle.
// Synchronous active-high reset clears lengths, load position, mode and
// handshake state; coefficient stores are not cleared.
module polynomial_add_sub_multiply_top #(
   parameter int MAX_TERMS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pasm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pasm_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [pasm_pkg::MODE_W-1:0]     csr_wr_data
);

   localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int POS_W  = pasm_pkg::POS_W;
   localparam int ACC_W  = pasm_pkg::ACC_W;
   localparam int CW     = pasm_pkg::COEFF_W;
   localparam int RND_SH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
   localparam logic signed [ACC_W-1:0] RND =
      (FRAC_BITS > 0) ? (ACC_W'(1) << RND_SH) : '0;
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TERMS);

   pasm_pkg::state_type state_ff, state_in;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  len_a_ff, len_a_in;
   logic [POS_W-1:0]  len_b_ff, len_b_in;
   logic [POS_W-1:0]  n_ff, n_in;
   logic [POS_W-1:0]  k_ff, k_in;
   logic [POS_W-1:0]  i_ff, i_in;
   logic [pasm_pkg::MODE_W-1:0] op_mode_ff, op_mode_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pasm_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              rd_vld_ff, mul_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [2*CW-1:0]   prod_ff;

   logic signed [CW-1:0] first_mem [MAX_TERMS];
   logic signed [CW-1:0] second_mem [MAX_TERMS];
   logic signed [CW-1:0] rd_a_ff, rd_b_ff;

   logic             req_fire, slot_free, start, is_mul, last_k, issue, rsp_load;
   logic             wr_a_en, wr_b_en;
   logic [IDX_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
   logic [POS_W-1:0] load_len, n_new, i_lo, i_hi, j_idx;
   logic [POS_W:0]   pos_inc;

   logic signed [CW:0]      add_a, add_b, add_res;
   logic signed [ACC_W-1:0] rnd_sum, rnd_shift;
   logic [ACC_W-CW:0]       rnd_upper;
   logic signed [CW-1:0]    res_coeff;
   logic                    res_clip;

   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_mul    = op_mode_ff[pasm_pkg::MODE_MUL_BIT];
   assign start     = req_fire && req_data.last_in && req_data.cmd;
   assign last_k    = (k_ff == n_ff - POS_W'(1));

   assign pos_inc  = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign load_len = (pos_inc > (POS_W+1)'(MAX_TERMS)) ? MAX_POS : pos_inc[POS_W-1:0];

   always_comb begin
      if (is_mul) begin
         n_new = (len_a_ff == '0) ? '0 : len_a_ff + load_len - POS_W'(1);
      end else begin
         n_new = (len_a_ff > load_len) ? len_a_ff : load_len;
      end
   end

   // term range for result power k: i from i_lo to i_hi, j = k - i
   assign i_lo  = (k_ff >= len_b_ff) ? k_ff - len_b_ff + POS_W'(1) : '0;
   assign i_hi  = (k_ff < len_a_ff) ? k_ff : len_a_ff - POS_W'(1);
   assign j_idx = k_ff - i_ff;

   assign wr_addr = pos_ff[IDX_W-1:0];
   assign wr_a_en = req_fire && (pos_ff < MAX_POS) && !req_data.cmd;
   assign wr_b_en = req_fire && (pos_ff < MAX_POS) && req_data.cmd;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pasm_pkg::ST_IDLE: begin
            if (start && n_new != '0) begin
               state_in = is_mul ? pasm_pkg::ST_MUL_INIT : pasm_pkg::ST_ADD_RD;
            end
         end
         pasm_pkg::ST_ADD_RD:   state_in = pasm_pkg::ST_ADD_CALC;
         pasm_pkg::ST_ADD_CALC: begin
            if (slot_free) begin
               state_in = last_k ? pasm_pkg::ST_IDLE : pasm_pkg::ST_ADD_RD;
            end
         end
         pasm_pkg::ST_MUL_INIT: state_in = pasm_pkg::ST_MUL_ISSUE;
         pasm_pkg::ST_MUL_ISSUE: begin
            if (i_ff == i_hi) begin
               state_in = pasm_pkg::ST_MUL_DRAIN;
            end
         end
         pasm_pkg::ST_MUL_DRAIN: begin
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = pasm_pkg::ST_MUL_OUT;
            end
         end
         pasm_pkg::ST_MUL_OUT: begin
            if (slot_free) begin
               state_in = last_k ? pasm_pkg::ST_IDLE : pasm_pkg::ST_MUL_INIT;
            end
         end
         default: state_in = pasm_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      rsp_load  = 1'b0;
      rd_a_addr = k_ff[IDX_W-1:0];
      rd_b_addr = k_ff[IDX_W-1:0];
      unique case (state_ff)
         pasm_pkg::ST_IDLE:      req_ready = 1'b1;
         pasm_pkg::ST_ADD_RD:    ;
         pasm_pkg::ST_ADD_CALC:  rsp_load = slot_free;
         pasm_pkg::ST_MUL_INIT:  ;
         pasm_pkg::ST_MUL_ISSUE: begin
            issue     = 1'b1;
            rd_a_addr = i_ff[IDX_W-1:0];
            rd_b_addr = j_idx[IDX_W-1:0];
         end
         pasm_pkg::ST_MUL_DRAIN: ;
         pasm_pkg::ST_MUL_OUT:   rsp_load = slot_free;
         default:                ;
      endcase
   end

   // sum / difference with saturation
   always_comb begin
      add_a   = (k_ff < len_a_ff) ? (CW+1)'(rd_a_ff) : '0;
      add_b   = (k_ff < len_b_ff) ? (CW+1)'(rd_b_ff) : '0;
      add_res = op_mode_ff[pasm_pkg::MODE_SUB_BIT] ? add_a - add_b : add_a + add_b;
      // product: round half up, shift, saturate
      rnd_sum   = acc_ff + RND;
      rnd_shift = rnd_sum >>> FRAC_BITS;
      rnd_upper = rnd_shift[ACC_W-1:CW-1];
      if (is_mul) begin
         res_clip  = !((&rnd_upper) || !(|rnd_upper));
         res_coeff = res_clip ? (rnd_shift[ACC_W-1] ? pasm_pkg::COEFF_MIN : pasm_pkg::COEFF_MAX)
                              : rnd_shift[CW-1:0];
      end else begin
         res_clip  = add_res[CW] != add_res[CW-1];
         res_coeff = res_clip ? (add_res[CW] ? pasm_pkg::COEFF_MIN : pasm_pkg::COEFF_MAX)
                              : add_res[CW-1:0];
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      acc_in       = acc_ff;
      op_mode_in   = op_mode_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         op_mode_in = csr_wr_data;
      end

      if (req_fire) begin
         if (!req_data.last_in) begin
            if (pos_ff < MAX_POS) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end else begin
            pos_in = '0;
            if (req_data.cmd) begin
               len_b_in = load_len;
               n_in     = n_new;
               k_in     = '0;
            end else begin
               len_a_in = load_len;
            end
         end
      end

      if (state_ff == pasm_pkg::ST_MUL_INIT) begin
         i_in   = i_lo;
         acc_in = '0;
      end
      if (issue) begin
         i_in = i_ff + POS_W'(1);
      end
      if (mul_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.coeff_out = res_coeff;
         rsp_data_in.power     = k_ff;
         rsp_data_in.last_out  = last_k;
         rsp_data_in.saturated = res_clip;
         k_in                  = k_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pasm_pkg::ST_IDLE;
         pos_ff       <= '0;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         op_mode_ff   <= pasm_pkg::OP_SUM;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         op_mode_ff   <= op_mode_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= issue;
         mul_vld_ff   <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= rd_a_ff * rd_b_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_a_en) begin
         first_mem[wr_addr] <= req_data.coeff_in;
      end
      rd_a_ff <= first_mem[rd_a_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_b_en) begin
         second_mem[wr_addr] <= req_data.coeff_in;
      end
      rd_b_ff <= second_mem[rd_b_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/polynomial_add_sub_multiply_top_tb.sv
module polynomial_add_sub_multiply_top_tb;

   localparam int COEFF_W      = pasm_pkg::COEFF_W;
   localparam int MODE_W       = pasm_pkg::MODE_W;
   localparam int POS_W        = pasm_pkg::POS_W;
   localparam int ACC_W        = pasm_pkg::ACC_W;
   localparam int MAX_TERMS    = 32;
   localparam int FRAC         = 16;
   localparam int RANDOM_ITEMS = 175;
   localparam int SETTLE       = 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PREDICTED    = -1;

   localparam logic CMD_FIRST  = 1'b0;
   localparam logic CMD_SECOND = 1'b1;
   // bit 1 alone decides product, so mode three multiplies too
   localparam logic [MODE_W-1:0] OP_MUL_ALT = pasm_pkg::OP_MUL | pasm_pkg::OP_SUB;

   typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_style_type;

   typedef struct {
      bit                        set_mode;
      logic [MODE_W-1:0]         mode;
      pasm_pkg::req_type         item;
      int                        typed_n;
      logic signed [COEFF_W-1:0] typed_coeff;
      logic                      typed_sat;
   } script_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   pasm_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   pasm_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [MODE_W-1:0] csr_wr_data = '0;

   // shadow of the block
   logic signed [COEFF_W-1:0] first_poly  [MAX_TERMS];
   logic signed [COEFF_W-1:0] second_poly [MAX_TERMS];
   bit                        first_seen  [MAX_TERMS];
   bit                        second_seen [MAX_TERMS];
   int                        filled_count = 0;
   int                        first_len    = 0;
   int                        second_len   = 0;
   int                        load_pos     = 0;
   logic [MODE_W-1:0]         cur_mode     = pasm_pkg::OP_SUM;

   pasm_pkg::rsp_type due_coeffs [$];
   script_row_type    script [$];
   pasm_pkg::rsp_type head;
   int                mismatches  = 0;
   int                sent_items  = 0;
   int                burst_left  = 0;
   int                cycle_count = 0;
   rx_style_type      rx_style    = RX_OPEN;
   int                rx_left     = 0;

   polynomial_add_sub_multiply_top #(
      .MAX_TERMS(MAX_TERMS),
      .FRAC_BITS(FRAC)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic signed [COEFF_W-1:0] clip32(longint v, output logic clipped);
      clipped = (v > pasm_pkg::COEFF_MAX) || (v < pasm_pkg::COEFF_MIN);
      if (v > pasm_pkg::COEFF_MAX)
         return pasm_pkg::COEFF_MAX;
      if (v < pasm_pkg::COEFF_MIN)
         return pasm_pkg::COEFF_MIN;
      return v[COEFF_W-1:0];
   endfunction

   // updates the shadow for one accepted item, queues the coefficients it releases
   function automatic int apply_load(pasm_pkg::req_type it);
      int                        n;
      int                        span;
      logic signed [ACC_W-1:0]   acc;
      logic signed [COEFF_W-1:0] a_term;
      logic signed [COEFF_W-1:0] b_term;
      longint                    total;
      logic                      clipped;
      pasm_pkg::rsp_type         r;
      if (load_pos < MAX_TERMS) begin
         if (it.cmd == CMD_FIRST) begin
            if (!first_seen[load_pos])
               filled_count++;
            first_seen[load_pos] = 1'b1;
            first_poly[load_pos] = it.coeff_in;
         end else begin
            if (!second_seen[load_pos])
               filled_count++;
            second_seen[load_pos] = 1'b1;
            second_poly[load_pos] = it.coeff_in;
         end
      end
      if (!it.last_in) begin
         if (load_pos < MAX_TERMS)
            load_pos++;
         return 0;
      end
      span = (load_pos + 1 > MAX_TERMS) ? MAX_TERMS : load_pos + 1;
      load_pos = 0;
      if (it.cmd == CMD_FIRST) begin
         first_len = span;
         return 0;
      end
      second_len = span;
      if (cur_mode[pasm_pkg::MODE_MUL_BIT]) begin
         if (first_len == 0 || second_len == 0)
            return 0;
         n = first_len + second_len - 1;
      end else begin
         n = (first_len > second_len) ? first_len : second_len;
      end
      for (int k = 0; k < n; k++) begin
         if (cur_mode[pasm_pkg::MODE_MUL_BIT]) begin
            acc = '0;
            for (int i = 0; i < first_len && i <= k; i++)
               if (k - i < second_len)
                  acc += longint'(first_poly[i]) * longint'(second_poly[k - i]);
            // round half up, then drop the fraction
            acc += ACC_W'(1) << (FRAC - 1);
            acc = acc >>> FRAC;
            total = longint'(acc);
         end else begin
            a_term = (k < first_len) ? first_poly[k] : '0;
            b_term = (k < second_len) ? second_poly[k] : '0;
            total = cur_mode[pasm_pkg::MODE_SUB_BIT] ? longint'(a_term) - longint'(b_term)
                                                     : longint'(a_term) + longint'(b_term);
         end
         r.coeff_out = clip32(total, clipped);
         r.saturated = clipped;
         r.power     = k[POS_W-1:0];
         r.last_out  = (k == n - 1);
         due_coeffs.push_back(r);
      end
      return n;
   endfunction

   function automatic script_row_type script_row(bit set_mode, logic [MODE_W-1:0] mode,
                                                 logic cmd, logic signed [COEFF_W-1:0] coeff,
                                                 logic last, int typed_n,
                                                 logic signed [COEFF_W-1:0] typed_coeff = '0,
                                                 logic typed_sat = 1'b0);
      script_row_type row;
      row.set_mode    = set_mode;
      row.mode        = mode;
      row.item        = '{cmd: cmd, coeff_in: coeff, last_in: last};
      row.typed_n     = typed_n;
      row.typed_coeff = typed_coeff;
      row.typed_sat   = typed_sat;
      return row;
   endfunction

   function automatic logic signed [COEFF_W-1:0] rand_coeff();
      case ($urandom_range(0, 7))
         0: return pasm_pkg::COEFF_MAX;
         1: return pasm_pkg::COEFF_MIN;
         2: return '0;
         3, 4: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
         default: return $urandom;
      endcase
   endfunction

   function automatic int draw_length();
      int r;
      r = $urandom_range(0, 15);
      if (r < 10)
         return $urandom_range(1, 4);
      if (r < 13)
         return $urandom_range(5, 12);
      if (r < 15)
         return MAX_TERMS;
      return $urandom_range(MAX_TERMS + 1, MAX_TERMS + 3);
   endfunction

   task automatic send_item(pasm_pkg::req_type it, output int produced);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      produced = apply_load(it);
      sent_items++;
   endtask

   task automatic send_poly(logic cmd, int len);
      int                produced;
      pasm_pkg::req_type it;
      for (int i = 0; i < len; i++) begin
         it = '{cmd: cmd, coeff_in: rand_coeff(), last_in: (i == len - 1)};
         send_item(it, produced);
      end
   endtask

   // mode may only change with the block idle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (due_coeffs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(logic [MODE_W-1:0] m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = m;
   endtask

   task automatic report_field(string field, longint want, longint got);
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_style <= rx_style_type'($urandom_range(0, 3));
         rx_left  <= $urandom_range(16, 80);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_style)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= (cycle_count[1:0] == 2'b00);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_coeffs.size() == 0) begin
            $display("%0t: unexpected item, expected none got %p", $time, rsp_data);
            mismatches++;
         end else begin
            head = due_coeffs.pop_front();
            if (rsp_data.coeff_out !== head.coeff_out)
               report_field("coeff_out", head.coeff_out, rsp_data.coeff_out);
            if (rsp_data.power !== head.power)
               report_field("power", head.power, rsp_data.power);
            if (rsp_data.last_out !== head.last_out)
               report_field("last_out", head.last_out, rsp_data.last_out);
            if (rsp_data.saturated !== head.saturated)
               report_field("saturated", head.saturated, rsp_data.saturated);
         end
      end
   end

   initial begin
      int                produced;
      int                choice;
      int                pick;
      pasm_pkg::req_type it;
      pasm_pkg::rsp_type typed;

      // first polynomial not loaded yet: sum passes the second, difference negates it
      script.push_back(script_row(0, pasm_pkg::OP_SUM, CMD_SECOND, 32'sh0001_0000, 1, 1,
                                  32'sh0001_0000, 0));
      script.push_back(script_row(1, pasm_pkg::OP_SUB, CMD_SECOND, pasm_pkg::COEFF_MIN, 1, 1,
                                  pasm_pkg::COEFF_MAX, 1));
      script.push_back(script_row(1, pasm_pkg::OP_MUL, CMD_SECOND, 32'sd5, 1, 0));
      // saturation at both ends
      script.push_back(script_row(1, pasm_pkg::OP_SUM, CMD_FIRST, pasm_pkg::COEFF_MAX, 1, 0));
      script.push_back(script_row(0, pasm_pkg::OP_SUM, CMD_SECOND, pasm_pkg::COEFF_MAX, 1, 1,
                                  pasm_pkg::COEFF_MAX, 1));
      script.push_back(script_row(1, pasm_pkg::OP_SUB, CMD_FIRST, pasm_pkg::COEFF_MIN, 1, 0));
      script.push_back(script_row(0, pasm_pkg::OP_SUB, CMD_SECOND, 32'sd1, 1, 1,
                                  pasm_pkg::COEFF_MIN, 1));
      script.push_back(script_row(0, pasm_pkg::OP_SUB, CMD_SECOND, pasm_pkg::COEFF_MIN, 1, 1,
                                  '0, 0));
      script.push_back(script_row(1, pasm_pkg::OP_MUL, CMD_SECOND, pasm_pkg::COEFF_MIN, 1, 1,
                                  pasm_pkg::COEFF_MAX, 1));
      script.push_back(script_row(0, pasm_pkg::OP_MUL, CMD_SECOND, 32'sh0001_0000, 1, 1,
                                  pasm_pkg::COEFF_MIN, 0));
      // rounding of a product that lands on one half LSB
      script.push_back(script_row(0, pasm_pkg::OP_MUL, CMD_FIRST, 32'sd1, 1, 0));
      script.push_back(script_row(0, pasm_pkg::OP_MUL, CMD_SECOND, 32'sh0000_8000, 1, 1,
                                  32'sd1, 0));
      script.push_back(script_row(0, pasm_pkg::OP_MUL, CMD_FIRST, -32'sd1, 1, 0));
      script.push_back(script_row(0, pasm_pkg::OP_MUL, CMD_SECOND, 32'sh0000_8000, 1, 1,
                                  '0, 0));
      script.push_back(script_row(1, OP_MUL_ALT, CMD_FIRST, 32'sh0002_8000, 0, PREDICTED));
      script.push_back(script_row(0, OP_MUL_ALT, CMD_FIRST, -32'sh0001_4000, 1, PREDICTED));
      script.push_back(script_row(0, OP_MUL_ALT, CMD_SECOND, 32'sh0003_0000, 0, PREDICTED));
      script.push_back(script_row(0, OP_MUL_ALT, CMD_SECOND, 32'sh1234_5678, 0, PREDICTED));
      script.push_back(script_row(0, OP_MUL_ALT, CMD_SECOND, -32'sh0000_C000, 1, PREDICTED));
      // unequal lengths
      script.push_back(script_row(1, pasm_pkg::OP_SUM, CMD_FIRST, 32'sh4000_0000, 0,
                                  PREDICTED));
      script.push_back(script_row(0, pasm_pkg::OP_SUM, CMD_FIRST, 32'sh4000_0000, 0,
                                  PREDICTED));
      script.push_back(script_row(0, pasm_pkg::OP_SUM, CMD_FIRST, -32'sd5, 1, PREDICTED));
      script.push_back(script_row(0, pasm_pkg::OP_SUM, CMD_SECOND, 32'sh4000_0000, 1,
                                  PREDICTED));
      // cmd switches mid-polynomial: position carries over into the other store
      script.push_back(script_row(1, pasm_pkg::OP_SUB, CMD_FIRST, 32'sd7, 0, PREDICTED));
      script.push_back(script_row(0, pasm_pkg::OP_SUB, CMD_SECOND, 32'sd9, 1, PREDICTED));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].set_mode) begin
            wait_quiet();
            write_mode(script[i].mode);
         end
         send_item(script[i].item, produced);
         if (script[i].typed_n != PREDICTED) begin
            repeat (produced) void'(due_coeffs.pop_back());
            if (script[i].typed_n == 1) begin
               typed = '{coeff_out: script[i].typed_coeff, power: '0, last_out: 1'b1,
                         saturated: script[i].typed_sat};
               due_coeffs.push_back(typed);
            end
         end
      end

      while (sent_items < script.size() + RANDOM_ITEMS) begin
         choice = $urandom_range(0, 9);
         if (choice == 0) begin
            wait_quiet();
            pick = $urandom_range(0, 3);
            write_mode(pick[MODE_W-1:0]);
         end else if (choice < 3 && filled_count == 2 * MAX_TERMS) begin
            // broken sequences only once no store entry is left unwritten
            repeat ($urandom_range(1, 6)) begin
               it = '{cmd: 1'($urandom_range(0, 1)), coeff_in: rand_coeff(),
                      last_in: ($urandom_range(0, 2) == 0)};
               send_item(it, produced);
            end
         end else begin
            if ($urandom_range(0, 4) != 0)
               send_poly(CMD_FIRST, draw_length());
            send_poly(CMD_SECOND, draw_length());
         end
      end

      req_valid <= 1'b0;
      while (due_coeffs.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
src/pasm_pkg.sv
src/polynomial_add_sub_multiply_top.sv
tb/polynomial_add_sub_multiply_top_tb.sv
